/* hdl/assert_macros.svh */
// Assertion macros shared by the debouncer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/pcd_pkg.sv */
// Shared types, widths and codes for the port connect debouncer.
// No dependencies; imported by every module of the block except pcd_ram.
package pcd_pkg;

    localparam int NUM_PORTS = 32;
    localparam int PORT_W    = 5;
    localparam int SLOT_W    = 6;
    localparam int CNT_W     = 8;
    localparam int PCNT_W    = 6;
    localparam int ACT_W     = 2;

    localparam logic [SLOT_W-1:0] MAX_SLOTS = SLOT_W'(32);
    localparam logic [CNT_W-1:0]  COUNT_CAP = CNT_W'(255);

    localparam logic [PCNT_W-1:0] PORT_COUNT_RST = PCNT_W'(32);
    localparam logic [CNT_W-1:0]  THRESHOLD_RST  = CNT_W'(3);

    // Operation codes carried on s_tuser.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_RECORD = 1'b1;

    // Action codes of a result word.
    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ENUM    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

    // Configuration register indexes.
    localparam logic REG_PORT_COUNT = 1'b0;
    localparam logic REG_THRESHOLD  = 1'b1;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic              level;
        logic [CNT_W-1:0]  count;
        logic [SLOT_W-1:0] slot;
    } port_entry_t;

    localparam int ENTRY_W = $bits(port_entry_t);

    typedef struct packed {
        logic              write_en;
        port_entry_t       entry;
        logic [ACT_W-1:0]  action;
    } upd_result_t;

endpackage

/* hdl/pcd_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies. A read of the address written in the same cycle returns old data.
module pcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/pcd_update.sv */
// Read-modify-write update of one port entry for a sample or a record word.
// Depends on pcd_pkg.
module pcd_update
    import pcd_pkg::*;
(
    input  logic              op,
    input  logic              connected,
    input  logic [SLOT_W-1:0] assigned_slot,
    input  logic              ignored,
    input  port_entry_t       entry_in,
    input  logic [CNT_W-1:0]  threshold,
    output upd_result_t       result
);

    logic             same_level;
    logic [CNT_W-1:0] cnt_new;

    assign same_level = (connected == entry_in.level);

    always_comb begin
        if (!same_level) begin
            cnt_new = CNT_W'(1);
        end else if (entry_in.count == COUNT_CAP) begin
            cnt_new = COUNT_CAP;
        end else begin
            cnt_new = entry_in.count + CNT_W'(1);
        end
    end

    always_comb begin
        result.write_en = !ignored;
        result.entry    = entry_in;
        result.action   = ACT_NONE;
        if (op == OP_SAMPLE) begin
            result.entry.level = connected;
            result.entry.count = cnt_new;
            if (cnt_new == threshold) begin
                if (connected) begin
                    if (entry_in.slot == '0) begin
                        result.action = ACT_ENUM;
                    end
                end else begin
                    // A disconnect at the threshold reports a release unless the port is ignored.
                    result.entry.slot = '0;
                    result.action     = ACT_RELEASE;
                end
            end
        end else begin
            if (assigned_slot <= MAX_SLOTS) begin
                result.entry.slot = assigned_slot;
            end
        end
        if (ignored) begin
            result.entry  = '0;
            result.action = ACT_NONE;
        end
    end

endmodule

/* hdl/port_connect_debouncer.sv */
// Top level of the port connect debouncer: stream ports, config registers,
// entry RAM, forwarding and output register. Depends on pcd_pkg, pcd_ram, pcd_update.
//
// The block takes one word per cycle unless the output register is full and
// stalled, and returns exactly one result word for each. Per-port level, count
// and slot live in a 32-entry RAM with a registered read; the word is held in
// stage one for that read, then updated and written back as its result is
// loaded into the output register once that register is free. A word that
// follows one for the same port takes the written data from a forwarding
// path. A valid bit per entry, cleared by reset, makes never-written entries
// read as zero, so no clearing pass runs. Ports at or above port_count return
// a zero result and change nothing.
`include "assert_macros.svh"

module port_connect_debouncer
    import pcd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Fields from bit 0 up: port[4:0], connected[5], assigned_slot[11:6], zero fill.
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Fields from bit 0 up: operation[0].
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Fields from bit 0 up: port_echo[4:0], action[6:5], current_slot[12:7],
    // stable_samples[20:13], zero fill.
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CNT_W-1:0]      cfg_wdata
);

    logic [PCNT_W-1:0]    port_count_reg;
    logic [CNT_W-1:0]     threshold_reg;

    logic                 st1_valid_reg;
    logic                 st1_op_reg;
    logic [PORT_W-1:0]    st1_port_reg;
    logic                 st1_conn_reg;
    logic [SLOT_W-1:0]    st1_slot_reg;
    logic                 st1_entry_valid_reg;
    logic                 st1_fwd_hit_reg;
    port_entry_t          st1_fwd_entry_reg;

    logic [NUM_PORTS-1:0] entry_valid_reg;
    logic [NUM_PORTS-1:0] entry_valid_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic                  in_accept;
    logic                  advance;
    logic [PORT_W-1:0]     in_port;
    logic                  in_conn;
    logic [SLOT_W-1:0]     in_slot;
    logic [ENTRY_W-1:0]    ram_rdata;
    port_entry_t           ram_entry;
    port_entry_t           merged_entry;
    logic                  ignored;
    logic                  wr_en;
    upd_result_t           upd;

    assign in_port = s_tdata[PORT_W-1:0];
    assign in_conn = s_tdata[PORT_W];
    assign in_slot = s_tdata[PORT_W+SLOT_W:PORT_W+1];

    assign advance   = st1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !st1_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_count_reg <= PORT_COUNT_RST;
            threshold_reg  <= THRESHOLD_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PORT_COUNT: port_count_reg <= cfg_wdata[PCNT_W-1:0];
                REG_THRESHOLD:  threshold_reg  <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    pcd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_PORTS)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (st1_port_reg),
        .wdata (upd.entry),
        .re    (in_accept),
        .raddr (in_port),
        .rdata (ram_rdata)
    );

    assign ram_entry = st1_entry_valid_reg ? port_entry_t'(ram_rdata) : '0;
    assign merged_entry = st1_fwd_hit_reg ? st1_fwd_entry_reg : ram_entry;
    assign ignored = !({1'b0, st1_port_reg} < port_count_reg);

    pcd_update u_update (
        .op            (st1_op_reg),
        .connected     (st1_conn_reg),
        .assigned_slot (st1_slot_reg),
        .ignored       (ignored),
        .entry_in      (merged_entry),
        .threshold     (threshold_reg),
        .result        (upd)
    );

    assign wr_en = advance && upd.write_en;

    always_comb begin
        entry_valid_next = entry_valid_reg;
        if (wr_en) begin
            entry_valid_next[st1_port_reg] = 1'b1;
        end
    end

    // Stage one control; the held word waits here for its RAM read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
        end else begin
            entry_valid_reg <= entry_valid_next;
            if (in_accept) begin
                st1_valid_reg <= 1'b1;
            end else if (advance) begin
                st1_valid_reg <= 1'b0;
            end
        end
    end

    // Stage one payload. A write to the same port in the accept cycle is
    // not seen by the RAM read, so it is captured here instead.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            st1_op_reg          <= s_tuser;
            st1_port_reg        <= in_port;
            st1_conn_reg        <= in_conn;
            st1_slot_reg        <= in_slot;
            st1_entry_valid_reg <= entry_valid_reg[in_port];
            st1_fwd_hit_reg     <= wr_en && (st1_port_reg == in_port);
            st1_fwd_entry_reg   <= upd.entry;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {3'b000, upd.entry.count, upd.entry.slot,
                             upd.action, st1_port_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `PCD_ASSERT_IMPL(a_wr_needs_word, aclk, aresetn, wr_en, st1_valid_reg && !ignored, "RAM write without a held word for a port in use")
    `PCD_ASSERT_IMPL(a_stall_only_full, aclk, aresetn, !s_tready, st1_valid_reg && out_valid_reg && !m_tready, "input stalled while the pipeline can move")
    `PCD_ASSERT_NEXT(a_advance_shows, aclk, aresetn, advance, m_tvalid, "result word not presented after an update")
    `PCD_ASSERT_IMPL(a_ignored_zero, aclk, aresetn, advance && ignored, upd.action == ACT_NONE && upd.entry == '0, "ignored port produced a nonzero result")

endmodule

/* bench/pcd_result_checker.sv */
// Result checker for the port connect debouncer: watches the stream channels
// and the register port, predicts each result word, and compares. Depends on pcd_pkg.
module pcd_result_checker
    import pcd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CNT_W-1:0]      cfg_wdata,
    output int                    words_due,
    output int                    mismatches
);

    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [ACT_W-1:0]  action;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count;
    } debounce_result_t;

    // Shadow copy of the per-port stores and the two registers.
    logic              level_q   [NUM_PORTS];
    logic [CNT_W-1:0]  run_len   [NUM_PORTS];
    logic [SLOT_W-1:0] held_slot [NUM_PORTS];
    logic [PCNT_W-1:0] ports_in_use;
    logic [CNT_W-1:0]  act_threshold;

    debounce_result_t due_results[$];

    initial begin
        words_due  = 0;
        mismatches = 0;
    end

    task automatic note_mismatch(string what, int got, int want);
        $display("[%0t] result mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic debounce_result_t debounce_step(logic op, logic [PORT_W-1:0] p,
                                                       logic lvl, logic [SLOT_W-1:0] slot_in);
        debounce_result_t r;
        r.port   = p;
        r.action = ACT_NONE;
        r.slot   = '0;
        r.count  = '0;
        // Ports at or above the port count leave everything alone and report zeros.
        if (PCNT_W'(p) < ports_in_use && int'(p) < NUM_PORTS) begin
            if (op == OP_SAMPLE) begin
                if (lvl == level_q[p]) begin
                    if (run_len[p] < COUNT_CAP)
                        run_len[p] = run_len[p] + CNT_W'(1);
                end else begin
                    level_q[p] = lvl;
                    run_len[p] = CNT_W'(1);
                end
                if (run_len[p] == act_threshold) begin
                    if (lvl) begin
                        if (held_slot[p] == '0)
                            r.action = ACT_ENUM;
                    end else begin
                        held_slot[p] = '0;
                        r.action     = ACT_RELEASE;
                    end
                end
            end else if (slot_in <= MAX_SLOTS) begin
                held_slot[p] = slot_in;
            end
            r.slot  = held_slot[p];
            r.count = run_len[p];
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        debounce_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_PORTS; i++) begin
                level_q[i]   = 1'b0;
                run_len[i]   = '0;
                held_slot[i] = '0;
            end
            ports_in_use  = PORT_COUNT_RST;
            act_threshold = THRESHOLD_RST;
            due_results.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_PORT_COUNT)
                    ports_in_use = cfg_wdata[PCNT_W-1:0];
                else
                    act_threshold = cfg_wdata;
            end
            if (s_tvalid && s_tready)
                due_results.push_back(debounce_step(s_tuser, s_tdata[4:0], s_tdata[5],
                                                    s_tdata[11:6]));
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    note_mismatch("unexpected word, none pending", int'(m_tdata), 0);
                end else begin
                    want = due_results.pop_front();
                    if (m_tdata[4:0] != want.port)
                        note_mismatch("port_echo", int'(m_tdata[4:0]), int'(want.port));
                    if (m_tdata[6:5] != want.action)
                        note_mismatch("action", int'(m_tdata[6:5]), int'(want.action));
                    if (m_tdata[12:7] != want.slot)
                        note_mismatch("current_slot", int'(m_tdata[12:7]), int'(want.slot));
                    if (m_tdata[20:13] != want.count)
                        note_mismatch("stable_samples", int'(m_tdata[20:13]),
                                      int'(want.count));
                end
            end
        end
        words_due <= due_results.size();
    end

endmodule

/* bench/tb_port_connect_debouncer.sv */
// Top of the port connect debouncer testbench: clock, reset, stimulus and verdict.
// Depends on pcd_pkg, port_connect_debouncer and pcd_result_checker.
module tb_port_connect_debouncer;
    import pcd_pkg::*;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [CNT_W-1:0]      cfg_wdata = '0;

    int   words_due;
    int   mismatches;
    logic quiet      = 1'b0;
    int   ready_left = 0;
    logic stim_level [NUM_PORTS];

    always #5 aclk = ~aclk;

    port_connect_debouncer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    pcd_result_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .words_due  (words_due),
        .mismatches (mismatches)
    );

    // Result side: random bursts of ready and stall, always ready once quiet.
    always @(posedge aclk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            ready_left <= $urandom_range(0, 7);
        end else begin
            m_tready   <= 1'b1;
            ready_left <= $urandom_range(0, 15);
        end
    end

    // Called just after a rising edge. Valid stays high on return so that a
    // following word can go out back to back.
    task automatic send_word(logic op, logic [PORT_W-1:0] p, logic lvl,
                             logic [SLOT_W-1:0] slot);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 8);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {4'b0000, slot, lvl, p};
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (words_due != 0);
    endtask

    // The caller lowers the write enable after its last write.
    task automatic write_reg(logic idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CNT_W'(value);
        @(posedge aclk);
    endtask

    // Mostly samples that keep each port's level for a while, so runs reach
    // the threshold; records are mixed in, with a little noise on any port.
    task automatic random_item(int span, int flip_div);
        int                r;
        logic [PORT_W-1:0] p;
        logic [SLOT_W-1:0] s;
        r = $urandom_range(0, 99);
        if (r < 8)
            p = PORT_W'($urandom_range(0, NUM_PORTS - 1));
        else
            p = PORT_W'($urandom_range(0, span - 1));
        if (r < 4) begin
            send_word(1'($urandom_range(0, 1)), p, 1'($urandom_range(0, 1)),
                      SLOT_W'($urandom_range(0, 63)));
        end else if (r < 20) begin
            if ($urandom_range(0, 5) == 0)
                s = SLOT_W'($urandom_range(0, 63));
            else
                s = SLOT_W'($urandom_range(0, 32));
            send_word(OP_RECORD, p, 1'($urandom_range(0, 1)), s);
        end else begin
            if ($urandom_range(1, flip_div) == 1)
                stim_level[p] = ~stim_level[p];
            send_word(OP_SAMPLE, p, stim_level[p], SLOT_W'($urandom_range(0, 63)));
        end
    endtask

    task automatic run_phase(int pc, int th, int span, int flip_div, int n, bit calm_tail);
        wait_drained();
        write_reg(REG_PORT_COUNT, pc);
        write_reg(REG_THRESHOLD, th);
        cfg_we <= 1'b0;
        for (int i = 0; i < n; i++) begin
            if (calm_tail && i >= n - 100)
                quiet <= 1'b1;
            random_item(span, flip_div);
        end
    endtask

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        for (int i = 0; i < NUM_PORTS; i++)
            stim_level[i] = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset settings: enumerate, record, release.
        repeat (3) send_word(OP_SAMPLE, 5'd0, 1'b1, 6'd0);
        send_word(OP_RECORD, 5'd0, 1'b0, 6'd32);
        send_word(OP_SAMPLE, 5'd0, 1'b1, 6'd63);
        // Slots above the maximum must leave the stored slot unchanged.
        send_word(OP_RECORD, 5'd0, 1'b1, 6'd33);
        send_word(OP_RECORD, 5'd0, 1'b0, 6'd63);
        repeat (3) send_word(OP_SAMPLE, 5'd0, 1'b0, 6'd0);
        // A port that never held a slot still reports the release.
        repeat (3) send_word(OP_SAMPLE, 5'd31, 1'b0, 6'd0);
        repeat (3) send_word(OP_SAMPLE, 5'd31, 1'b1, 6'd0);
        send_word(OP_RECORD, 5'd31, 1'b1, 6'd1);
        send_word(OP_RECORD, 5'd31, 1'b0, 6'd0);
        // Connected port that already holds a slot: no request at the threshold.
        send_word(OP_RECORD, 5'd5, 1'b0, 6'd21);
        repeat (3) send_word(OP_SAMPLE, 5'd5, 1'b1, 6'd0);
        wait_drained();
        write_reg(REG_PORT_COUNT, 4);
        cfg_we <= 1'b0;
        send_word(OP_SAMPLE, 5'd31, 1'b1, 6'd0);
        send_word(OP_RECORD, 5'd4, 1'b0, 6'd7);
        send_word(OP_SAMPLE, 5'd3, 1'b1, 6'd0);

        // Random part over several settings, including both extremes.
        run_phase(32, 3, 32, 8, 150, 1'b0);
        run_phase(1, 1, 1, 3, 80, 1'b0);
        // Long steady runs on one port drive its counter into saturation.
        run_phase(63, 255, 1, 100000, 450, 1'b0);
        run_phase(0, 3, 32, 8, 40, 1'b0);
        run_phase(5, 2, 5, 4, 150, 1'b0);
        run_phase(20, 0, 20, 6, 60, 1'b0);
        run_phase(32, 8, 32, 16, 150, 1'b1);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
